### rtl/core/pflt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pflt_pkg
// Shared types, codes and sizes of the prime field log table ALU.
// ----------------------------------------------------------------------------
package pflt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  localparam int OPC_W  = 3;
  localparam int OPA_W  = 32;
  localparam int ELEM_W = 8;
  localparam int STAT_W = 2;
  localparam int REM_NW = 6;

  localparam logic [OPC_W-1:0] OP_BUILD  = 3'd0;
  localparam logic [OPC_W-1:0] OP_REDUCE = 3'd1;
  localparam logic [OPC_W-1:0] OP_ADD    = 3'd2;
  localparam logic [OPC_W-1:0] OP_NEG    = 3'd3;
  localparam logic [OPC_W-1:0] OP_MUL    = 3'd4;
  localparam logic [OPC_W-1:0] OP_INV    = 3'd5;
  localparam logic [OPC_W-1:0] OP_DIV    = 3'd6;
  localparam logic [OPC_W-1:0] OP_NONE   = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_DIV = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_TABLE = 2'd3;

  // Register index taken from paddr[2].
  localparam logic REG_PRIME = 1'b0;

  // Request to the shared remainder unit.
  typedef struct packed {
    logic              start;
    logic [OPA_W-1:0]  dividend;
    logic [REM_NW-1:0] nbits;
    logic [ELEM_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ELEM_W-1:0] rem;
  } rem_rsp_t;

endpackage

### rtl/core/pflt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pflt_in_if
// Input item channel: opcode and two operands with valid/ready.
// ----------------------------------------------------------------------------
interface pflt_in_if
  import pflt_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic signed [OPA_W-1:0] operand_a;
  logic [ELEM_W-1:0]       operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input opcode, input operand_a, input operand_b,
                  output ready);
endinterface

### rtl/core/pflt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pflt_out_if
// Result item channel: field element and status with valid/ready.
// ----------------------------------------------------------------------------
interface pflt_out_if
  import pflt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] result;
  logic [STAT_W-1:0] status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

### rtl/core/pflt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pflt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pflt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/pflt_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pflt_rem
// Shared restoring remainder unit: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pflt_rem
  import pflt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic [OPA_W-1:0]  sh;
  logic [REM_NW-1:0] cnt;
  logic [ELEM_W-1:0] div;
  logic [ELEM_W-1:0] r;
  logic              run;
  logic              done;
  logic [ELEM_W:0]   trial;

  // The partial remainder stays below the divisor, so one subtract suffices.
  assign trial = {r, sh[OPA_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.nbits;
        div <= req.divisor;
        r   <= '0;
        // Left-align the dividend so that its top bit is taken first.
        sh  <= req.dividend << (REM_NW'(OPA_W) - req.nbits);
      end else if (run) begin
        sh  <= sh << 1;
        cnt <= cnt - REM_NW'(1);
        if (trial >= {1'b0, div}) begin
          r <= ELEM_W'(trial - {1'b0, div});
        end else begin
          r <= trial[ELEM_W-1:0];
        end
        if (cnt == REM_NW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = run;
  assign rsp.done = done;
  assign rsp.rem  = r;

endmodule

### rtl/core/prime_field_log_table_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_field_log_table_alu
// GF(p) arithmetic over exp/log tables with primitive root search.
// ----------------------------------------------------------------------------
// The unit takes one item at a time and is not ready until that item has left
// its sequencer; a finished result waits in the output register while the
// next item is taken. Every reduction modulo p or p-1 runs through one shared
// remainder unit that retires one dividend bit per cycle, so item latency is
// set by that unit and by the registered table reads. Build tests the order
// of each candidate root one multiplication at a time, then computes each of
// the first p-1 table entries with one multiplication and writes the closing
// entry. The prime register is written over the APB port at address 0; a
// changed value marks the tables as not built.
// ----------------------------------------------------------------------------
module prime_field_log_table_alu
  import pflt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pflt_in_if.sink     in_ch,
  pflt_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_DISPATCH = 18'h00002,
    S_ORD      = 18'h00004,
    S_ORD_MUL  = 18'h00008,
    S_FILL     = 18'h00010,
    S_FILL_MUL = 18'h00020,
    S_RED_WAIT = 18'h00040,
    S_RD_LA    = 18'h00080,
    S_REM_LA   = 18'h00100,
    S_WAIT_LA  = 18'h00200,
    S_RD_LB    = 18'h00400,
    S_REM_LB   = 18'h00800,
    S_WAIT_LB  = 18'h01000,
    S_REM_IDX  = 18'h02000,
    S_WAIT_IDX = 18'h04000,
    S_RD_POW   = 18'h08000,
    S_POW_DATA = 18'h10000,
    S_DONE     = 18'h20000
  } state_t;

  state_t            state;
  logic [OPC_W-1:0]  op;
  logic [OPA_W-1:0]  a;
  logic [ELEM_W-1:0] b;
  logic [ELEM_W-1:0] prime;
  logic              tables_ready;
  logic [ELEM_W-1:0] generator;
  logic [ELEM_W-1:0] cand;
  logic [ELEM_W-1:0] q;
  logic [ELEM_W-1:0] ord;
  logic [ELEM_W-1:0] idx_i;
  logic [ELEM_W-1:0] n;
  logic [ELEM_W-1:0] la;
  logic [ELEM_W-1:0] lb;
  logic [ELEM_W-1:0] idx;
  logic [ELEM_W-1:0] res;
  logic [STAT_W-1:0] st;
  logic              out_valid;
  logic [ELEM_W-1:0] out_result;
  logic [STAT_W-1:0] out_status;

  logic [ELEM_W-1:0]   m;
  logic                a_neg;
  logic [OPA_W-1:0]    a_mag;
  logic                rng_bad;
  logic                ord_go;
  logic                fill_go;
  logic [ELEM_W:0]     idx_sum;
  logic [2*ELEM_W-1:0] prod;
  logic                cfg_we;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  logic              pow_we;
  logic [TBL_AW-1:0] pow_waddr;
  logic [ELEM_W-1:0] pow_wdata;
  logic [TBL_AW-1:0] pow_raddr;
  logic [ELEM_W-1:0] pow_rdata;
  logic              log_we;
  logic [TBL_AW-1:0] log_waddr;
  logic [ELEM_W-1:0] log_wdata;
  logic [TBL_AW-1:0] log_raddr;
  logic [ELEM_W-1:0] log_rdata;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_PRIME) ? {24'd0, prime} : 32'd0;

  // --------------------------------------------------------------------------
  // Shared datapath terms
  // --------------------------------------------------------------------------
  assign m       = prime - ELEM_W'(1);
  assign a_neg   = a[OPA_W-1];
  assign a_mag   = a_neg ? (OPA_W'(0) - a) : a;
  // A negative operand is also above p when read as unsigned.
  assign rng_bad = (a >= {24'd0, prime}) ||
                   (((op == OP_ADD) || (op == OP_MUL) || (op == OP_DIV)) && (b >= prime));
  assign ord_go  = (q != ELEM_W'(1)) && (ord < prime);
  assign fill_go = ({1'b0, idx_i} + 9'd1) < {1'b0, prime};

  always_comb begin
    case (op)
      OP_MUL:  idx_sum = {1'b0, la} + {1'b0, lb};
      OP_INV:  idx_sum = {1'b0, m} - {1'b0, la};
      default: idx_sum = {1'b0, la} + {1'b0, m} - {1'b0, lb};
    endcase
  end

  always_comb begin
    if (state == S_FILL) begin
      prod = n * generator;
    end else begin
      prod = q * cand;
    end
  end

  always_comb begin
    rem_req.start    = 1'b0;
    rem_req.dividend = {16'd0, prod};
    rem_req.nbits    = REM_NW'(16);
    rem_req.divisor  = prime;
    pow_we    = 1'b0;
    pow_waddr = TBL_AW'(idx_i);
    pow_wdata = n;
    log_we    = 1'b0;
    log_waddr = TBL_AW'(n);
    log_wdata = idx_i;
    pow_raddr = TBL_AW'(idx);
    log_raddr = (state == S_RD_LB) ? TBL_AW'(b) : TBL_AW'(a[ELEM_W-1:0]);
    case (state)
      S_DISPATCH: begin
        if (tables_ready && (op == OP_REDUCE)) begin
          rem_req.start    = 1'b1;
          rem_req.dividend = a_mag;
          rem_req.nbits    = REM_NW'(32);
        end else if (tables_ready && (op == OP_ADD) && !rng_bad) begin
          rem_req.start    = 1'b1;
          rem_req.dividend = OPA_W'({1'b0, a[ELEM_W-1:0]} + {1'b0, b});
          rem_req.nbits    = REM_NW'(9);
        end
      end
      S_ORD: begin
        rem_req.start = ord_go;
      end
      S_FILL: begin
        pow_we = 1'b1;
        log_we = 1'b1;
        if (fill_go) begin
          rem_req.start = 1'b1;
        end else begin
          // Closing entries: zero sits at exponent p-1.
          pow_waddr = TBL_AW'(m);
          pow_wdata = '0;
          log_waddr = '0;
          log_wdata = m;
        end
      end
      S_REM_LA, S_REM_LB: begin
        rem_req.start    = 1'b1;
        rem_req.dividend = OPA_W'(log_rdata);
        rem_req.nbits    = REM_NW'(8);
        rem_req.divisor  = m;
      end
      S_REM_IDX: begin
        rem_req.start    = 1'b1;
        rem_req.dividend = OPA_W'(idx_sum);
        rem_req.nbits    = REM_NW'(9);
        rem_req.divisor  = m;
      end
      default: begin
      end
    endcase
  end

  pflt_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  pflt_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_pow_ram (
    .clk   (clk),
    .we    (pow_we),
    .waddr (pow_waddr),
    .wdata (pow_wdata),
    .raddr (pow_raddr),
    .rdata (pow_rdata)
  );

  pflt_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_log_ram (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wdata),
    .raddr (log_raddr),
    .rdata (log_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_ch.ready   = (state == S_IDLE);
  assign out_ch.valid  = out_valid;
  assign out_ch.result = out_result;
  assign out_ch.status = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prime        <= 8'd2;
      tables_ready <= 1'b0;
      generator    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op    <= in_ch.opcode;
            a     <= in_ch.operand_a;
            b     <= in_ch.operand_b;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res   <= '0;
          st    <= ST_OK;
          state <= S_DONE;
          if (op == OP_NONE) begin
            state <= S_DONE;
          end else if (op == OP_BUILD) begin
            if (prime < 8'd2) begin
              st <= ST_NO_TABLE;
            end else if (prime == 8'd2) begin
              generator <= 8'd1;
              idx_i     <= '0;
              n         <= 8'd1;
              state     <= S_FILL;
            end else begin
              cand  <= 8'd2;
              q     <= 8'd2;
              ord   <= 8'd1;
              state <= S_ORD;
            end
          end else if (!tables_ready) begin
            st <= ST_NO_TABLE;
          end else if (op == OP_REDUCE) begin
            state <= S_RED_WAIT;
          end else if (rng_bad) begin
            st <= ST_RANGE;
          end else begin
            case (op)
              OP_ADD: state <= S_RED_WAIT;
              OP_NEG: begin
                res <= (a[ELEM_W-1:0] == '0) ? '0 : prime - a[ELEM_W-1:0];
              end
              OP_MUL: begin
                if ((a[ELEM_W-1:0] != '0) && (b != '0)) begin
                  state <= S_RD_LA;
                end
              end
              OP_INV: begin
                if (a[ELEM_W-1:0] == '0) begin
                  st <= ST_ZERO_DIV;
                end else begin
                  state <= S_RD_LA;
                end
              end
              default: begin
                if (b == '0) begin
                  st <= ST_ZERO_DIV;
                end else if (a[ELEM_W-1:0] != '0) begin
                  state <= S_RD_LA;
                end
              end
            endcase
          end
        end
        S_ORD: begin
          if (ord_go) begin
            state <= S_ORD_MUL;
          end else if (ord >= m) begin
            generator <= cand;
            idx_i     <= '0;
            n         <= 8'd1;
            state     <= S_FILL;
          end else if ((cand + 8'd1) == prime) begin
            // No candidate has full order: fall back to p-1.
            generator <= m;
            idx_i     <= '0;
            n         <= 8'd1;
            state     <= S_FILL;
          end else begin
            cand <= cand + 8'd1;
            q    <= cand + 8'd1;
            ord  <= 8'd1;
          end
        end
        S_ORD_MUL: begin
          if (rem_rsp.done) begin
            q     <= rem_rsp.rem;
            ord   <= ord + 8'd1;
            state <= S_ORD;
          end
        end
        S_FILL: begin
          if (fill_go) begin
            state <= S_FILL_MUL;
          end else begin
            tables_ready <= 1'b1;
            res          <= generator;
            st           <= ST_OK;
            state        <= S_DONE;
          end
        end
        S_FILL_MUL: begin
          if (rem_rsp.done) begin
            n     <= rem_rsp.rem;
            idx_i <= idx_i + 8'd1;
            state <= S_FILL;
          end
        end
        S_RED_WAIT: begin
          if (rem_rsp.done) begin
            if ((op == OP_REDUCE) && a_neg && (rem_rsp.rem != '0)) begin
              res <= prime - rem_rsp.rem;
            end else begin
              res <= rem_rsp.rem;
            end
            state <= S_DONE;
          end
        end
        S_RD_LA:  state <= S_REM_LA;
        S_REM_LA: state <= S_WAIT_LA;
        S_WAIT_LA: begin
          if (rem_rsp.done) begin
            la    <= rem_rsp.rem;
            state <= (op == OP_INV) ? S_REM_IDX : S_RD_LB;
          end
        end
        S_RD_LB:  state <= S_REM_LB;
        S_REM_LB: state <= S_WAIT_LB;
        S_WAIT_LB: begin
          if (rem_rsp.done) begin
            lb    <= rem_rsp.rem;
            state <= S_REM_IDX;
          end
        end
        S_REM_IDX: state <= S_WAIT_IDX;
        S_WAIT_IDX: begin
          if (rem_rsp.done) begin
            idx   <= rem_rsp.rem;
            state <= S_RD_POW;
          end
        end
        S_RD_POW: state <= S_POW_DATA;
        S_POW_DATA: begin
          res   <= pow_rdata;
          st    <= ST_OK;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_result <= res;
            out_status <= st;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we && (paddr[2] == REG_PRIME)) begin
        if (pwdata[ELEM_W-1:0] != prime) begin
          tables_ready <= 1'b0;
        end
        prime <= pwdata[ELEM_W-1:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_start_free: assert property (@(posedge clk) disable iff (rst)
    rem_req.start |-> !rem_rsp.busy)
    else $error("remainder unit started while busy");

  a_ready_from_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(tables_ready) |-> $past(state) == S_FILL)
    else $error("tables marked ready outside the fill sweep");

  a_prime_change_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (paddr[2] == REG_PRIME) && (pwdata[ELEM_W-1:0] != prime))
      |=> !tables_ready)
    else $error("prime changed but tables still marked ready");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ch.ready) |=> state == S_DONE)
    else $error("finished item dropped while the output register was full");
`endif

endmodule

### tb/sv/pflt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pflt_checker
// Watches the item channels and the APB port of the prime field ALU, keeps
// its own copy of the field, generator and exp/log tables, and compares every
// result item with the oldest prediction. Register reads are checked too.
// ----------------------------------------------------------------------------
module pflt_checker
  import pflt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pflt_in_if          in_ch,
  pflt_out_if         out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [ELEM_W-1:0] result;
    logic [STAT_W-1:0] status;
  } gf_answer_t;

  logic [ELEM_W-1:0] exp_tab [TABLE_DEPTH];
  logic [ELEM_W-1:0] log_tab [TABLE_DEPTH];
  logic [ELEM_W-1:0] root_q;
  logic              built_q;
  logic [ELEM_W-1:0] prime_q;
  gf_answer_t        gf_answer_q [$];

  // Smallest candidate whose multiplicative order reaches p-1.
  function automatic int unsigned smallest_root(input int unsigned p);
    int unsigned cand;
    int unsigned q;
    int unsigned ord;
    if (p == 2) return 1;
    for (cand = 2; cand < p; cand++) begin
      q   = cand;
      ord = 1;
      while (q != 1 && ord < p) begin
        q = (q * cand) % p;
        ord++;
      end
      if (ord >= p - 1) return cand;
    end
    return p - 1;
  endfunction

  task automatic fill_tables(input int unsigned p);
    int unsigned g;
    int unsigned n;
    int unsigned i;
    g      = smallest_root(p);
    root_q = g[ELEM_W-1:0];
    n      = 1;
    for (i = 0; i + 1 < p; i++) begin
      exp_tab[i % TABLE_DEPTH] = n[ELEM_W-1:0];
      log_tab[n % TABLE_DEPTH] = i[ELEM_W-1:0];
      n = (n * g) % p;
    end
    exp_tab[(p - 1) % TABLE_DEPTH] = '0;
    log_tab[0] = ELEM_W'(p - 1);
    built_q    = 1'b1;
  endtask

  task automatic gf_evaluate(input logic [OPC_W-1:0] op, input logic [OPA_W-1:0] a_raw,
                             input logic [ELEM_W-1:0] b, output gf_answer_t ans);
    int unsigned p;
    int unsigned m;
    int unsigned a;
    int unsigned bb;
    int unsigned la;
    int unsigned lb;
    int unsigned mag;
    int unsigned res;
    logic [STAT_W-1:0] st;
    p   = prime_q;
    m   = p - 1;
    a   = a_raw;
    bb  = b;
    res = 0;
    st  = ST_OK;
    if (op == OP_NONE) begin
      res = 0;
    end else if (op == OP_BUILD) begin
      if (p < 2) begin
        st = ST_NO_TABLE;
      end else begin
        fill_tables(p);
        res = root_q;
      end
    end else if (!built_q) begin
      st = ST_NO_TABLE;
    end else if (op == OP_REDUCE) begin
      // A negative value is reduced through its magnitude.
      if (a_raw[OPA_W-1]) begin
        mag = (32'd0 - a_raw) % p;
        res = (mag == 0) ? 0 : p - mag;
      end else begin
        res = a % p;
      end
    end else if (a_raw[OPA_W-1] || a >= p ||
                 ((op == OP_ADD || op == OP_MUL || op == OP_DIV) && bb >= p)) begin
      st = ST_RANGE;
    end else begin
      case (op)
        OP_ADD: begin
          res = a + bb;
          if (res >= p) res = res - p;
        end
        OP_NEG: begin
          res = (a == 0) ? 0 : p - a;
        end
        OP_MUL: begin
          if (a != 0 && bb != 0) begin
            la  = log_tab[a] % m;
            lb  = log_tab[bb] % m;
            res = exp_tab[(la + lb) % m];
          end
        end
        OP_INV: begin
          if (a == 0) begin
            st = ST_ZERO_DIV;
          end else begin
            la  = log_tab[a] % m;
            res = exp_tab[(m - la) % m];
          end
        end
        OP_DIV: begin
          if (bb == 0) begin
            st = ST_ZERO_DIV;
          end else if (a != 0) begin
            la  = log_tab[a] % m;
            lb  = log_tab[bb] % m;
            res = exp_tab[(la + m - lb) % m];
          end
        end
        default: res = 0;
      endcase
    end
    ans.opcode = op;
    ans.result = res[ELEM_W-1:0];
    ans.status = st;
  endtask

  always @(posedge clk) begin : watch
    gf_answer_t ans;
    gf_answer_t want;
    int         i;
    if (rst) begin
      for (i = 0; i < TABLE_DEPTH; i++) begin
        exp_tab[i] = '0;
        log_tab[i] = '0;
      end
      root_q     = '0;
      built_q    = 1'b0;
      prime_q    = ELEM_W'(2);
      fail_count = 0;
      gf_answer_q.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_PRIME) begin
        if (pwrite) begin
          if (pwdata[ELEM_W-1:0] != prime_q) built_q = 1'b0;
          prime_q = pwdata[ELEM_W-1:0];
        end else if (prdata !== {24'd0, prime_q}) begin
          $error("prdata mismatch: expected %0d, actual %0d", prime_q, prdata);
          fail_count++;
        end
      end
      // The item leaving this edge is older than any item taken at it.
      if (out_ch.valid && out_ch.ready) begin
        if (gf_answer_q.size() == 0) begin
          $error("result item with nothing outstanding: result %0d, status %0d",
                 out_ch.result, out_ch.status);
          fail_count++;
        end else begin
          want = gf_answer_q.pop_front();
          if (out_ch.result !== want.result) begin
            $error("result mismatch (opcode %0d): expected %0d, actual %0d",
                   want.opcode, want.result, out_ch.result);
            fail_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status mismatch (opcode %0d): expected %0d, actual %0d",
                   want.opcode, want.status, out_ch.status);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        gf_evaluate(in_ch.opcode, in_ch.operand_a, in_ch.operand_b, ans);
        gf_answer_q.push_back(ans);
      end
    end
    outstanding = gf_answer_q.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the prime field ALU: a directed pass over the edge cases, then
// random sets, each with its own prime, usually a table build and a run of field
// operations, under changing flow control on both channels.
// ----------------------------------------------------------------------------
module tb
  import pflt_pkg::*;
;

  typedef enum logic [1:0] {IDLE_RECV_HEAVY, IDLE_SEND_HEAVY, IDLE_OFF} idle_mode_t;

  localparam logic [2:0] PRIME_ADDR = {REG_PRIME, 2'b00};
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned fail_count;
  int unsigned outstanding;

  idle_mode_t  idle_mode;
  int unsigned cur_prime;
  int unsigned rand_items;
  int unsigned set_len;
  int unsigned hold_left;
  bit          hold_done;

  pflt_in_if  in_ch ();
  pflt_out_if out_ch ();

  prime_field_log_table_alu u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pflt_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned send_idle_pct(input idle_mode_t mode);
    case (mode)
      IDLE_RECV_HEAVY: return 28;
      IDLE_SEND_HEAVY: return 79;
      default:         return 0;
    endcase
  endfunction

  function automatic int unsigned recv_idle_pct(input idle_mode_t mode);
    case (mode)
      IDLE_RECV_HEAVY: return 79;
      IDLE_SEND_HEAVY: return 28;
      default:         return 0;
    endcase
  endfunction

  function automatic bit is_prime(input int unsigned n);
    int unsigned d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Small fields are favoured, as a build in a large one is slow.
  function automatic int unsigned pick_prime();
    int unsigned n;
    do begin
      n = ($urandom_range(2) != 0) ? $urandom_range(31, 2) : $urandom_range(251, 2);
    end while (!is_prime(n));
    return n;
  endfunction

  // Result side: random stalls, plus one long hold-off once idling stops, so
  // that the unit fills up while the sender keeps offering items.
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_mode == IDLE_OFF && in_ch.valid && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct(idle_mode));
      end
    end
  end

  task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Valid stays high after an item is taken; the next call either replaces
  // the item or drops valid, so it is never lowered and raised in one step.
  task automatic send_item(input logic [OPC_W-1:0] op, input logic [OPA_W-1:0] a,
                           input logic [ELEM_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct(idle_mode)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_prime(input int unsigned p);
    wait_idle();
    apb_xfer(1'b1, PRIME_ADDR, p);
    apb_xfer(1'b0, PRIME_ADDR, 32'd0);
    cur_prime = p;
  endtask

  task automatic send_random_op();
    int unsigned      roll;
    int unsigned      p;
    logic [OPC_W-1:0] op;
    logic [OPA_W-1:0] a;
    logic [ELEM_W-1:0] b;
    p    = cur_prime;
    roll = $urandom_range(99);
    if (roll < 2) op = OP_NONE;
    else if (roll < 3 && p < 32) op = OP_BUILD;
    else op = OPC_W'($urandom_range(int'(OP_DIV), int'(OP_REDUCE)));

    roll = $urandom_range(99);
    if (op == OP_REDUCE) begin
      if (roll < 30) a = $urandom_range(1200) - 32'd600;
      else a = $urandom();
    end else if (roll < 8) begin
      a = '0;
    end else if (roll < 14) begin
      a = p - 1;
    end else if (roll < 22) begin
      a = $urandom();
    end else begin
      a = $urandom_range(p - 1);
    end

    roll = $urandom_range(99);
    if (roll < 8) b = '0;
    else if (roll < 14) b = ELEM_W'(p - 1);
    else if (roll < 24) b = ELEM_W'($urandom_range(255));
    else b = ELEM_W'($urandom_range(p - 1));

    send_item(op, a, b);
    if (op != OP_NONE) rand_items++;
  endtask

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_NONE;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    idle_mode       = IDLE_RECV_HEAVY;
    cur_prime       = 2;
    rand_items      = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Reset state: p is 2 and no tables exist yet.
    apb_xfer(1'b0, PRIME_ADDR, 32'd0);
    send_item(OP_REDUCE, 32'd5, 8'd0);
    send_item(OP_NONE, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_BUILD, 32'hDEAD_BEEF, 8'hAA);
    send_item(OP_INV, 32'd1, 8'd0);
    send_item(OP_MUL, 32'd1, 8'd1);
    send_item(OP_ADD, 32'd1, 8'd1);

    // Largest prime that fits the register.
    set_prime(251);
    send_item(OP_BUILD, 32'd0, 8'd0);
    send_item(OP_REDUCE, 32'h8000_0000, 8'd0);
    send_item(OP_REDUCE, 32'h7FFF_FFFF, 8'd0);
    send_item(OP_REDUCE, 32'hFFFF_FFFF, 8'd0);
    send_item(OP_ADD, 32'd250, 8'd250);
    send_item(OP_NEG, 32'd0, 8'd255);
    send_item(OP_MUL, 32'd0, 8'd7);
    send_item(OP_MUL, 32'd7, 8'd0);
    send_item(OP_MUL, 32'd250, 8'd250);
    send_item(OP_INV, 32'd0, 8'd0);
    send_item(OP_INV, 32'd1, 8'd0);
    send_item(OP_DIV, 32'd5, 8'd0);
    send_item(OP_DIV, 32'd0, 8'd5);
    send_item(OP_ADD, 32'd251, 8'd0);
    send_item(OP_NEG, 32'hFFFF_FFFF, 8'd0);
    send_item(OP_MUL, 32'd3, 8'd251);
    send_item(OP_DIV, 32'd3, 8'd255);

    // A field order below two refuses the build.
    set_prime(1);
    send_item(OP_BUILD, 32'd0, 8'd0);
    send_item(OP_MUL, 32'd0, 8'd0);

    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items < RANDOM_ITEMS / 3) idle_mode = IDLE_RECV_HEAVY;
      else if (rand_items < 2 * RANDOM_ITEMS / 3) idle_mode = IDLE_SEND_HEAVY;
      else idle_mode = IDLE_OFF;
      set_prime(pick_prime());
      // Now and then the tables are left unbuilt after a change of prime.
      if ($urandom_range(9) != 0) begin
        send_item(OP_BUILD, $urandom(), ELEM_W'($urandom_range(255)));
        rand_items++;
      end
      set_len = $urandom_range(70, 30);
      repeat (set_len) send_random_op();
    end

    wait_idle();
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
